FILE: hdl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared types and constants of the block run-length track decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

  // field widths fixed by the item formats
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned TrackBits = 16;
  localparam int unsigned CountBits = 15;
  localparam int unsigned CapBits   = 22;

  // capacity after reset
  localparam logic [CapBits-1:0] CapReset = 22'd32768;

  // result kinds
  localparam logic KindRun  = 1'b0;
  localparam logic KindDone = 1'b1;

  // command queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // one input request
  typedef struct packed {
    logic [ByteBits-1:0]  data_byte;
    logic                 track_start;
    logic [TrackBits-1:0] trk_len;
  } in_item_t;

  // one result
  typedef struct packed {
    logic                 kind;
    logic [ByteBits-1:0]  run_value;
    logic [CountBits-1:0] run_count;
    logic [CapBits-1:0]   total_len;
    logic                 last;
  } out_item_t;

  // queue entry: a run, a track-done report, or both (run first)
  typedef struct packed {
    logic                 run_v;
    logic [ByteBits-1:0]  run_value;
    logic [CountBits-1:0] run_count;
    logic                 done_v;
    logic [CapBits-1:0]   total_len;
  } rtd_cmd_t;

endpackage

FILE: hdl/block_rle_track_decoder_unit.sv
// ----------------------------------------------------------------------------
// block_rle_track_decoder_unit
// Run-length track decoder: compressed track bytes in, value/count runs and
// a per-track total out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one compressed byte per request (in_valid_i / in_stall_o),
//   track_start and trk_len marking the first byte of a track.
//   Output channel: runs (kind 0) and one done report (kind 1, last set)
//   per track that reaches its end (out_valid_o / out_stall_i).
//   cfg_we_i / cfg_wdata_i write the capacity; write only while idle.
//   Throughput: one byte per cycle while the queue is not full. A byte yields
//   at most one queue entry; the back end sends one result per cycle unless
//   stalled, a run then a done report for a track's last byte closing a run.
//   Path: an accepted byte's command is written into the queue, then loaded
//   into the result register, from which its result can be taken.
//   A four-entry command queue sits between the parser and the output
//   register; in_stall_o rises only when that queue is full, so a stalled
//   receiver backs up the queue before the input is held off.
//   Reset: parser idle, queue empty, no result pending, capacity 32768.
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module block_rle_track_decoder_unit
  import rtd_pkg::*;
#(
  parameter int unsigned OUT_COUNT_BITS = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CapBits-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  logic     q_push;
  logic     q_pop;
  logic     q_empty;
  logic     q_full;
  rtd_cmd_t q_in;
  rtd_cmd_t q_head;
  logic     accept;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // parser
  rtd_front #(
    .OUT_COUNT_BITS(OUT_COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .push_o     (q_push),
    .cmd_o      (q_in)
  );

  // command queue
  rtd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // result stage
  rtd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // queue never written when full, never read when empty
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command queue underflow");

  // a presented run always carries a non-zero count
  a_run_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KindRun)) |-> (out_data_o.run_count != '0))
    else $error("run with zero count");

  // nothing presented in the cycle after reset releases
  a_reset_idle : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result presented straight after reset");

endmodule

FILE: hdl/rtd_front.sv
// ----------------------------------------------------------------------------
// rtd_front
// Parses the compressed byte stream: header, fill and literal tracking,
// capacity clipping, and issue of run / done commands to the queue.
// ----------------------------------------------------------------------------
module rtd_front
  import rtd_pkg::*;
#(
  parameter int unsigned OUT_COUNT_BITS = 22
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CapBits-1:0]  cfg_wdata_i,
  input  logic                accept_i,
  input  in_item_t            item_i,
  output logic                push_o,
  output rtd_cmd_t            cmd_o
);

  localparam int unsigned CW = (OUT_COUNT_BITS > CapBits) ? OUT_COUNT_BITS : CapBits;
  localparam logic [CW-1:0] CapLim = CW'({OUT_COUNT_BITS{1'b1}});

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhHdrLo = 3'd1;
  localparam logic [2:0] PhHdrHi = 3'd2;
  localparam logic [2:0] PhFill  = 3'd3;
  localparam logic [2:0] PhLit   = 3'd4;

  logic [CapBits-1:0]        cap_q;
  logic [2:0]                phase_q, phase_d;
  logic [ByteBits-1:0]       hdr_lo_q, hdr_lo_d;
  logic [TrackBits-1:0]      trk_rem_q, trk_rem_d;
  logic [CountBits-1:0]      blk_rem_q, blk_rem_d;
  logic [OUT_COUNT_BITS-1:0] out_cnt_q, out_cnt_d;
  logic                      stopped_q, stopped_d;

  // working copies: a track start resets the state before the byte is used
  logic [2:0]                ph;
  logic [ByteBits-1:0]       hl;
  logic [TrackBits-1:0]      tr;
  logic [CountBits-1:0]      br;
  logic [OUT_COUNT_BITS-1:0] oc;
  logic                      stp;

  logic [CW-1:0]        cap_eff;
  logic [CW-1:0]        oc_ext;
  logic [CW-1:0]        room;
  logic                 full;
  logic [CountBits-1:0] fill_cnt;
  logic [CountBits-1:0] hdr_len;
  logic [TrackBits-1:0] tr_dec;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    ph  = item_i.track_start ? PhHdrLo : phase_q;
    hl  = item_i.track_start ? '0 : hdr_lo_q;
    tr  = item_i.track_start ? item_i.trk_len : trk_rem_q;
    br  = item_i.track_start ? '0 : blk_rem_q;
    oc  = item_i.track_start ? '0 : out_cnt_q;
    stp = item_i.track_start ? 1'b0 : stopped_q;
  end

  // capacity arithmetic
  always_comb begin
    cap_eff  = (CW'(cap_q) < CapLim) ? CW'(cap_q) : CapLim;
    oc_ext   = CW'(oc);
    full     = (oc_ext >= cap_eff);
    room     = cap_eff - oc_ext;
    fill_cnt = (CW'(br) < room) ? br : room[CountBits-1:0];
    hdr_len  = {item_i.data_byte[6:0], hl};
    tr_dec   = tr - 16'd1;
  end

  // next state and command
  always_comb begin
    phase_d   = phase_q;
    hdr_lo_d  = hdr_lo_q;
    trk_rem_d = trk_rem_q;
    blk_rem_d = blk_rem_q;
    out_cnt_d = out_cnt_q;
    stopped_d = stopped_q;
    push_o    = 1'b0;
    cmd_o     = '0;

    if (accept_i) begin
      if (item_i.track_start && (item_i.trk_len == '0)) begin
        // empty track: report at once
        phase_d   = PhIdle;
        hdr_lo_d  = '0;
        trk_rem_d = '0;
        blk_rem_d = '0;
        out_cnt_d = '0;
        stopped_d = 1'b0;
        push_o    = 1'b1;
        cmd_o.done_v = 1'b1;
      end else if (ph != PhIdle) begin
        phase_d   = ph;
        hdr_lo_d  = hl;
        blk_rem_d = br;
        out_cnt_d = oc;
        stopped_d = stp;

        if (!stp) begin
          unique case (ph)
            PhHdrLo: begin
              if (full) begin
                stopped_d = 1'b1;
              end else begin
                hdr_lo_d = item_i.data_byte;
                phase_d  = PhHdrHi;
              end
            end
            PhHdrHi: begin
              if (hdr_len == '0) begin
                stopped_d = 1'b1;
              end else if (item_i.data_byte[7]) begin
                blk_rem_d = hdr_len;
                phase_d   = PhFill;
              end else if (TrackBits'(hdr_len) > tr_dec) begin
                stopped_d = 1'b1;
              end else begin
                blk_rem_d = hdr_len;
                phase_d   = PhLit;
              end
            end
            PhFill: begin
              if (full) begin
                stopped_d = 1'b1;
              end else begin
                push_o          = 1'b1;
                cmd_o.run_v     = 1'b1;
                cmd_o.run_value = item_i.data_byte;
                cmd_o.run_count = fill_cnt;
                out_cnt_d       = oc + OUT_COUNT_BITS'(fill_cnt);
                phase_d         = PhHdrLo;
              end
            end
            PhLit: begin
              if (!full) begin
                push_o          = 1'b1;
                cmd_o.run_v     = 1'b1;
                cmd_o.run_value = item_i.data_byte;
                cmd_o.run_count = 15'd1;
                out_cnt_d       = oc + 1'b1;
              end
              blk_rem_d = br - 15'd1;
              if (br == 15'd1) begin
                phase_d = PhHdrLo;
              end
            end
            default: begin
              stopped_d = 1'b1;
            end
          endcase
        end

        // track bookkeeping
        trk_rem_d = tr_dec;
        if (tr_dec == '0) begin
          push_o          = 1'b1;
          cmd_o.done_v    = 1'b1;
          cmd_o.total_len = CapBits'(out_cnt_d);
          phase_d         = PhIdle;
          stopped_d       = 1'b0;
          blk_rem_d       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      hdr_lo_q  <= '0;
      trk_rem_q <= '0;
      blk_rem_q <= '0;
      out_cnt_q <= '0;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_lo_q  <= hdr_lo_d;
      trk_rem_q <= trk_rem_d;
      blk_rem_q <= blk_rem_d;
      out_cnt_q <= out_cnt_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

FILE: hdl/rtd_fifo.sv
// ----------------------------------------------------------------------------
// rtd_fifo
// Short command queue decoupling the parser from the result stage.
// ----------------------------------------------------------------------------
module rtd_fifo
  import rtd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rtd_cmd_t push_data_i,
  input  logic     pop_i,
  output rtd_cmd_t head_o,
  output logic     empty_o,
  output logic     full_o
);

  rtd_cmd_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/rtd_back.sv
// ----------------------------------------------------------------------------
// rtd_back
// Result stage: takes queued commands and presents run and done results
// from a register, a run before the done report of the same command.
// ----------------------------------------------------------------------------
module rtd_back
  import rtd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rtd_cmd_t  head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  rtd_cmd_t cur_q;
  logic     cur_v_q;
  logic     run_pend_q;
  logic     advance;
  logic     finish;

  assign advance = cur_v_q && !out_stall_i;
  assign finish  = advance && !(run_pend_q && cur_q.done_v);
  assign pop_o   = (!cur_v_q || finish) && !empty_i;

  // result formatting
  always_comb begin
    out_valid_o = cur_v_q;
    out_data_o  = '0;
    if (run_pend_q) begin
      out_data_o.kind      = KindRun;
      out_data_o.run_value = cur_q.run_value;
      out_data_o.run_count = cur_q.run_count;
    end else begin
      out_data_o.kind      = KindDone;
      out_data_o.total_len = cur_q.total_len;
      out_data_o.last      = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q    <= 1'b0;
      run_pend_q <= 1'b0;
    end else if (pop_o) begin
      cur_v_q    <= 1'b1;
      run_pend_q <= head_i.run_v;
    end else if (finish) begin
      cur_v_q    <= 1'b0;
      run_pend_q <= 1'b0;
    end else if (advance) begin
      // run taken, done report follows
      run_pend_q <= 1'b0;
    end
  end

endmodule

FILE: bench/rtd_scoreboard.sv
// ----------------------------------------------------------------------------
// rtd_scoreboard
// Watches both channels of the run-length track decoder, decodes every
// accepted request in its own copy of the parser and checks each result
// against the oldest decoded item still waiting.
// ----------------------------------------------------------------------------
module rtd_scoreboard
  import rtd_pkg::*;
#(
  parameter int unsigned OUT_COUNT_BITS = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CapBits-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 runs_o,
  output int                 tracks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // largest count the decoder's counter can hold
  localparam longint unsigned CountLim = (64'd1 << OUT_COUNT_BITS) - 64'd1;

  typedef enum logic [2:0] {
    PhIdle,
    PhHdrLo,
    PhHdrHi,
    PhFill,
    PhLit
  } parse_ph_e;

  // parser copy
  logic [CapBits-1:0]   cap_reg;
  parse_ph_e            ph;
  logic [ByteBits-1:0]  hdr_low;
  logic [TrackBits-1:0] trk_rem;
  logic [CountBits-1:0] blk_rem;
  int unsigned          out_count;
  bit                   stopped;

  // decoded items not yet seen on the output
  out_item_t decoded_q[$];

  task automatic push_run(input logic [ByteBits-1:0] val, input logic [CountBits-1:0] cnt);
    out_item_t item;
    item           = '0;
    item.kind      = KindRun;
    item.run_value = val;
    item.run_count = cnt;
    decoded_q.push_back(item);
  endtask

  task automatic push_done(input int unsigned total);
    out_item_t item;
    item           = '0;
    item.kind      = KindDone;
    item.total_len = total[CapBits-1:0];
    item.last      = 1'b1;
    decoded_q.push_back(item);
  endtask

  // one compressed byte through the parser
  task automatic decode_byte(input in_item_t it);
    int unsigned cap;
    int unsigned len;
    int unsigned room;
    int unsigned cnt;
    cap = (longint'(cap_reg) < CountLim) ? int'(cap_reg) : CountLim[31:0];

    // a track start resets the parser, even mid-track
    if (it.track_start) begin
      out_count = 0;
      stopped   = 1'b0;
      hdr_low   = '0;
      blk_rem   = '0;
      if (it.trk_len == '0) begin
        trk_rem = '0;
        ph      = PhIdle;
        push_done(0);
        return;
      end
      trk_rem = it.trk_len;
      ph      = PhHdrLo;
    end
    if (ph == PhIdle) return;

    if (!stopped) begin
      case (ph)
        PhHdrLo: begin
          if (out_count >= cap) begin
            stopped = 1'b1;
          end else begin
            hdr_low = it.data_byte;
            ph      = PhHdrHi;
          end
        end
        PhHdrHi: begin
          len = {it.data_byte[6:0], hdr_low};
          if (len == 0) begin
            stopped = 1'b1;
          end else if (it.data_byte[7]) begin
            blk_rem = len[CountBits-1:0];
            ph      = PhFill;
          end else if (len + 1 > trk_rem) begin
            // literal runs past the track end
            stopped = 1'b1;
          end else begin
            blk_rem = len[CountBits-1:0];
            ph      = PhLit;
          end
        end
        PhFill: begin
          if (out_count >= cap) begin
            stopped = 1'b1;
          end else begin
            room = cap - out_count;
            cnt  = (blk_rem < room) ? blk_rem : room;
            push_run(it.data_byte, cnt[CountBits-1:0]);
            out_count += cnt;
            ph = PhHdrLo;
          end
        end
        PhLit: begin
          // bytes beyond capacity are swallowed
          if (out_count < cap) begin
            push_run(it.data_byte, 15'd1);
            out_count += 1;
          end
          blk_rem = blk_rem - 1'b1;
          if (blk_rem == '0) ph = PhHdrLo;
        end
        default: stopped = 1'b1;
      endcase
    end

    // track end closes with the total
    trk_rem = trk_rem - 1'b1;
    if (trk_rem == '0) begin
      push_done(out_count);
      ph      = PhIdle;
      stopped = 1'b0;
      blk_rem = '0;
    end
  endtask

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got)
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    return want === got;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    bit ok;
    if (decoded_q.size() == 0) begin
      $display("%0t ns: result with nothing expected, actual %0h", $time, got);
      fail_count_o++;
      return;
    end
    want = decoded_q.pop_front();
    ok = field_ok("kind", 32'(want.kind), 32'(got.kind));
    ok = field_ok("run_value", 32'(want.run_value), 32'(got.run_value)) & ok;
    ok = field_ok("run_count", 32'(want.run_count), 32'(got.run_count)) & ok;
    ok = field_ok("total_len", 32'(want.total_len), 32'(got.total_len)) & ok;
    ok = field_ok("last", 32'(want.last), 32'(got.last)) & ok;
    if (!ok) fail_count_o++;
    else if (want.kind == KindRun) runs_o++;
    else tracks_o++;
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_reg      = CapReset;
      ph           = PhIdle;
      hdr_low      = '0;
      trk_rem      = '0;
      blk_rem      = '0;
      out_count    = 0;
      stopped      = 1'b0;
      fail_count_o = 0;
      runs_o       = 0;
      tracks_o     = 0;
      decoded_q.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      pending_o <= decoded_q.size();
    end
  end

endmodule

FILE: bench/block_rle_track_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// block_rle_track_decoder_unit_test
// Stimulus and verdict for the run-length track decoder: directed tracks for
// the edge cases, then phases of random tracks (mostly well formed, some
// broken) under changing capacities, with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module block_rle_track_decoder_unit_test
  import rtd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CntBits      = 22;
  localparam int          RandItems    = 1850;
  localparam int          QuietTail    = 300;
  localparam int          HoldCycles   = 48;
  localparam int          SettleCycles = 8;
  localparam int unsigned LimitCycles  = 400000;
  localparam logic [CapBits-1:0] CapMax = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CapBits-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;

  int fail_count;
  int pending;
  int runs;
  int tracks;

  // stimulus controls
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          gap_pct = 20;
  int          stall_pct = 20;
  int          req_sent = 0;
  int          req_ignored = 0;
  int          cap_settings = 0;
  int unsigned cycle_cnt = 0;

  logic [7:0] trk_bytes[$];

  block_rle_track_decoder_unit #(
    .OUT_COUNT_BITS(CntBits)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  rtd_scoreboard #(
    .OUT_COUNT_BITS(CntBits)
  ) u_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .runs_o      (runs),
    .tracks_o    (tracks)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LimitCycles) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && ($urandom_range(0, 99) < stall_pct)) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one request; called at a falling edge, returns at the falling edge after
  // it was taken
  task automatic send_byte(input logic [7:0] b, input logic st, input logic [15:0] tl);
    in_item_t it;
    int unsigned gap;
    gap = 0;
    if (!quiet && ($urandom_range(0, 99) < gap_pct)) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.data_byte   = b;
    it.track_start = st;
    it.trk_len     = tl;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    req_sent++;
  endtask

  // first n bytes of the built track, start flag on the first
  task automatic send_track(input logic [15:0] tl, input int n);
    for (int i = 0; i < n; i++) begin
      if (i == 0) send_byte(trk_bytes[0], 1'b1, tl);
      else send_byte(trk_bytes[i], 1'b0, 16'($urandom));
    end
    trk_bytes.delete();
  endtask

  task automatic add_hdr(input int unsigned len, input bit fill);
    trk_bytes.push_back(len[7:0]);
    trk_bytes.push_back({fill, len[14:8]});
  endtask

  // well-formed blocks with random content
  task automatic add_blocks(input int nb);
    int unsigned len;
    repeat (nb) begin
      if ($urandom_range(0, 1) == 1) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 40);
        add_hdr(len, 1'b1);
        trk_bytes.push_back(8'($urandom));
      end else begin
        len = $urandom_range(1, 6);
        add_hdr(len, 1'b0);
        repeat (len) trk_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CapBits-1:0] c);
    cfg_wdata <= c;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_settings++;
  endtask

  task automatic random_track();
    int unsigned r;
    int n;
    int k;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      add_blocks($urandom_range(1, 4));
      send_track(16'(trk_bytes.size()), trk_bytes.size());
    end else if (r < 67) begin
      // empty track
      send_byte(8'($urandom), 1'b1, 16'd0);
    end else if (r < 73) begin
      // zero block length stops decoding
      add_blocks($urandom_range(0, 2));
      add_hdr(0, 1'($urandom));
      repeat ($urandom_range(0, 3)) trk_bytes.push_back(8'($urandom));
      send_track(16'(trk_bytes.size()), trk_bytes.size());
    end else if (r < 79) begin
      // literal longer than the rest of the track
      add_blocks($urandom_range(0, 2));
      k   = $urandom_range(0, 4);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(k + 1, 32767)
                                        : k + $urandom_range(1, 12);
      add_hdr(len, 1'b0);
      repeat (k) trk_bytes.push_back(8'($urandom));
      send_track(16'(trk_bytes.size()), trk_bytes.size());
    end else if (r < 86) begin
      // track length cuts the stream short
      add_blocks($urandom_range(1, 3));
      n = trk_bytes.size();
      k = $urandom_range(1, 3);
      if (k > n - 1) k = n - 1;
      send_track(16'(n - k), n - k);
    end else if (r < 92) begin
      // dropped by the next track start
      add_blocks($urandom_range(1, 4));
      n = trk_bytes.size();
      send_track(16'($urandom_range(n, 65535)), $urandom_range(1, n - 1));
    end else if (r < 96) begin
      n = $urandom_range(1, 12);
      repeat (n) trk_bytes.push_back(8'($urandom));
      send_track(16'(n), n);
    end else begin
      // bytes with no track start
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom), 1'b0, 16'($urandom));
      req_ignored += n;
    end
  endtask

  initial begin
    int base;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed tracks under the reset capacity
    send_byte(8'h5A, 1'b1, 16'd0);
    trk_bytes = '{8'hFF, 8'hFF, 8'hAA};
    send_track(16'd3, 3);
    trk_bytes = '{8'h02, 8'h00, 8'h00, 8'hFF, 8'h07};
    send_track(16'd5, 5);
    trk_bytes = '{8'h00, 8'h00, 8'h11};
    send_track(16'd3, 3);
    trk_bytes = '{8'h05, 8'h00, 8'h01, 8'h02};
    send_track(16'd4, 4);
    send_byte(8'hC3, 1'b0, 16'hFFFF);
    trk_bytes = '{8'h01, 8'h80};
    send_track(16'hFFFF, 2);
    trk_bytes = '{8'h00, 8'h80, 8'h22};
    send_track(16'd3, 3);

    // capacity lowered under a parsed fill header
    drain_pipeline();
    set_capacity(22'd6);
    trk_bytes = '{8'h04, 8'h80, 8'h33, 8'h01, 8'h80};
    send_track(16'd6, 5);
    drain_pipeline();
    set_capacity(22'd2);
    send_byte(8'h44, 1'b0, 16'h0000);

    // truncation of a fill run and of a literal
    drain_pipeline();
    set_capacity(22'd3);
    trk_bytes = '{8'h02, 8'h80, 8'h77, 8'h02, 8'h00, 8'h01, 8'h02};
    send_track(16'd7, 7);

    // receiver holds off while a long literal streams in
    base = req_sent - req_ignored;
    drain_pipeline();
    set_capacity(CapMax);
    hold_req = 1'b1;
    add_hdr(36, 1'b0);
    repeat (36) trk_bytes.push_back(8'($urandom));
    send_track(16'(trk_bytes.size()), trk_bytes.size());

    // random phases, each under its own capacity
    while (req_sent - req_ignored - base < RandItems) begin
      drain_pipeline();
      case ($urandom_range(0, 9))
        0:       set_capacity('0);
        1:       set_capacity(22'd1);
        2:       set_capacity(22'($urandom_range(2, 20)));
        3:       set_capacity(22'($urandom_range(21, 300)));
        4:       set_capacity(CapReset);
        5:       set_capacity(CapMax);
        6:       set_capacity(22'($urandom));
        default: set_capacity(22'($urandom_range(301, 60000)));
      endcase
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 35;
      endcase
      if (req_sent - req_ignored - base > RandItems - QuietTail) quiet = 1'b1;
      repeat ($urandom_range(6, 14)) random_track();
    end

    drain_pipeline();
    $display("Covered %0d requests over %0d capacity settings", req_sent, cap_settings);
    $display("Checked %0d runs and %0d track totals", runs, tracks);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
